### hw/rtl/csl_pkg.sv
// Shared types, token codes and keyword table of the C source lexer.
package csl_pkg;

    localparam int KEYWORD_MAX_LEN_DEF = 8;
    localparam int LINE_BITS_DEF       = 16;
    localparam int COLUMN_BITS_DEF     = 12;
    localparam int TOK_MAX             = 4;
    localparam int QUEUE_DEPTH         = 4;
    localparam int KW_COUNT            = 17;

    localparam logic [5:0] K_ELLIPSIS  = 6'd32;
    localparam logic [5:0] K_DOT       = 6'd31;
    localparam logic [5:0] K_NUM       = 6'd33;
    localparam logic [5:0] K_STRING    = 6'd34;
    localparam logic [5:0] K_CHARACTER = 6'd35;
    localparam logic [5:0] K_IDENT     = 6'd36;
    localparam logic [5:0] K_KEYWORD0  = 6'd37;
    localparam logic [5:0] K_END       = 6'd54;
    localparam logic [5:0] K_ERROR     = 6'd55;

    localparam logic [1:0] E_NONE      = 2'd0;
    localparam logic [1:0] E_UNKNOWN   = 2'd1;
    localparam logic [1:0] E_OPEN_COM  = 2'd2;
    localparam logic [1:0] E_OPEN_LIT  = 2'd3;

    localparam logic [63:0] KW_WORD [KW_COUNT] = '{
        64'("return"), 64'("if"), 64'("else"), 64'("int"), 64'("char"),
        64'("while"), 64'("sizeof"), 64'("for"), 64'("struct"),
        64'("typedef"), 64'("goto"), 64'("switch"), 64'("case"),
        64'("default"), 64'("break"), 64'("enum"), 64'("continue")};
    localparam int KW_LEN [KW_COUNT] = '{6, 2, 4, 3, 4, 5, 6, 3, 6, 7, 4, 6, 4, 7, 5, 4, 8};

    typedef enum logic [3:0] {
        M_IDLE, M_OP, M_LCOM, M_BCOM, M_BSTAR, M_STR, M_CBODY, M_CESC,
        M_CCLOSE, M_NUM, M_IDENT
    } t_mode;

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] line;
        logic [11:0] col;
        logic [15:0] len;
        logic [7:0]  lit;
        logic [1:0]  err;
    } t_tok;

    // tokens caused by one source byte
    typedef struct packed {
        logic [2:0]              cnt;
        t_tok [TOK_MAX-1:0]      toks;
    } t_rec;

endpackage

### hw/rtl/csl_front.sv
// Scanner: classifies each source byte and builds the record of tokens it completes.
module csl_front import csl_pkg::*; #(
    parameter int KEYWORD_MAX_LEN = KEYWORD_MAX_LEN_DEF,
    parameter int LINE_BITS       = LINE_BITS_DEF,
    parameter int COLUMN_BITS     = COLUMN_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_source_byte,
    input  logic       i_final_byte,
    input  logic       i_full,
    output logic       o_push,
    output t_rec       o_rec
);

    localparam int IW = $clog2(KEYWORD_MAX_LEN);
    localparam logic [LINE_BITS-1:0]   LMAX = {LINE_BITS{1'b1}};
    localparam logic [COLUMN_BITS-1:0] CMAX = {COLUMN_BITS{1'b1}};

    t_mode                  r_mode, n_mode;
    logic [7:0]             r_pend, n_pend;
    logic [15:0]            r_len, n_len;
    logic [LINE_BITS-1:0]   r_line, n_line, r_tsl, n_tsl;
    logic [COLUMN_BITS-1:0] r_col, n_col, r_tsc, n_tsc;
    logic [7:0]             r_esc, n_esc;
    logic [7:0]             r_kw [KEYWORD_MAX_LEN];
    logic [7:0]             n_kw [KEYWORD_MAX_LEN];
    logic                   kw_we;
    logic [IW-1:0]          kw_idx;
    t_rec                   rec;
    logic                   accept;

    function automatic t_tok mk_tok(input logic [5:0] kind, input logic [LINE_BITS-1:0] line,
                                    input logic [COLUMN_BITS-1:0] col, input logic [15:0] len,
                                    input logic [7:0] lit, input logic [1:0] err);
        t_tok        t;
        logic [31:0] l32;
        logic [31:0] c32;
        l32 = 32'(line);
        c32 = 32'(col);
        t.kind = kind;
        t.line = l32[15:0];
        t.col  = c32[11:0];
        t.len  = len;
        t.lit  = lit;
        t.err  = err;
        return t;
    endfunction

    function automatic logic [15:0] inc_len(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic [COLUMN_BITS-1:0] inc_col(input logic [COLUMN_BITS-1:0] v);
        return (v == CMAX) ? v : v + COLUMN_BITS'(1);
    endfunction

    function automatic logic [8:0] held_kind(input logic [7:0] b);
        logic [8:0] r;
        case (b)
            "+":     r = {1'b1, 8'd0};
            "-":     r = {1'b1, 8'd3};
            "/":     r = {1'b1, 8'd8};
            "=":     r = {1'b1, 8'd9};
            "!":     r = {1'b1, 8'd11};
            ">":     r = {1'b1, 8'd13};
            "<":     r = {1'b1, 8'd15};
            "&":     r = {1'b1, 8'd17};
            "|":     r = {1'b1, 8'd19};
            ".":     r = {1'b1, 8'd31};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [8:0] imm_kind(input logic [7:0] b);
        logic [8:0] r;
        case (b)
            "*":     r = {1'b1, 8'd7};
            "(":     r = {1'b1, 8'd21};
            ")":     r = {1'b1, 8'd22};
            "{":     r = {1'b1, 8'd23};
            "}":     r = {1'b1, 8'd24};
            "[":     r = {1'b1, 8'd25};
            "]":     r = {1'b1, 8'd26};
            ";":     r = {1'b1, 8'd27};
            ":":     r = {1'b1, 8'd28};
            ",":     r = {1'b1, 8'd29};
            "?":     r = {1'b1, 8'd30};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [8:0] pair_kind(input logic [7:0] h, input logic [7:0] b);
        logic [8:0] r;
        r = 9'd0;
        if (h == "+" && b == "+") r = {1'b1, 8'd1};
        if (h == "+" && b == "=") r = {1'b1, 8'd2};
        if (h == "-" && b == "-") r = {1'b1, 8'd4};
        if (h == "-" && b == "=") r = {1'b1, 8'd5};
        if (h == "-" && b == ">") r = {1'b1, 8'd6};
        if (h == "=" && b == "=") r = {1'b1, 8'd10};
        if (h == "!" && b == "=") r = {1'b1, 8'd12};
        if (h == ">" && b == "=") r = {1'b1, 8'd14};
        if (h == "<" && b == "=") r = {1'b1, 8'd16};
        if (h == "&" && b == "&") r = {1'b1, 8'd18};
        if (h == "|" && b == "|") r = {1'b1, 8'd20};
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    endfunction

    // w holds the first eight identifier bytes, byte 0 in the low bits
    function automatic logic [5:0] classify(input logic [63:0] w, input logic [15:0] n);
        logic [63:0] pw [1:8];
        logic [5:0]  k;
        logic        found;
        k = K_IDENT;
        found = 1'b0;
        for (int l = 1; l <= 8; l++) begin
            pw[l] = 64'd0;
            for (int j = 0; j < l; j++) begin
                pw[l][8*(l-1-j) +: 8] = w[8*j +: 8];
            end
        end
        for (int i = 0; i < KW_COUNT; i++) begin
            if (!found && n == 16'(KW_LEN[i]) && pw[KW_LEN[i]] == KW_WORD[i]) begin
                found = 1'b1;
                k = K_KEYWORD0 + 6'(i);
            end
        end
        if (n > 16'(KEYWORD_MAX_LEN)) k = K_IDENT;
        return k;
    endfunction

    always_comb begin
        logic [7:0]             b;
        logic [COLUMN_BITS-1:0] col;
        logic                   do_idle;
        logic                   do_flush;
        logic [8:0]             hk;
        logic [8:0]             pk;
        logic [63:0]            wv;
        n_mode = r_mode;
        n_pend = r_pend;
        n_len  = r_len;
        n_tsl  = r_tsl;
        n_tsc  = r_tsc;
        n_esc  = r_esc;
        n_kw   = r_kw;
        kw_we  = 1'b0;
        kw_idx = '0;
        rec    = '0;
        b      = i_source_byte;
        col    = inc_col(r_col);
        do_idle  = 1'b0;
        do_flush = 1'b0;
        hk = 9'd0;
        pk = 9'd0;
        wv = 64'd0;
        for (int j = 0; j < 8; j++) wv[8*j +: 8] = r_kw[j];

        case (r_mode)
            M_OP: begin
                pk = pair_kind(r_pend, b);
                if (r_len >= 16'd2) begin
                    if (b == ".") begin
                        n_len = inc_len(r_len);
                        rec.toks[rec.cnt[1:0]] = mk_tok(K_ELLIPSIS, r_tsl, r_tsc, n_len,
                                                        8'd0, E_NONE);
                        rec.cnt = rec.cnt + 3'd1;
                        n_mode = M_IDLE;
                    end else begin
                        do_flush = 1'b1;
                        do_idle  = 1'b1;
                    end
                end else if (r_pend == "/" && b == "/") begin
                    n_mode = M_LCOM;
                end else if (r_pend == "/" && b == "*") begin
                    n_len  = inc_len(r_len);
                    n_mode = M_BCOM;
                end else if (r_pend == "." && b == ".") begin
                    n_len = inc_len(r_len);
                end else if (pk[8]) begin
                    n_len = inc_len(r_len);
                    rec.toks[rec.cnt[1:0]] = mk_tok(pk[5:0], r_tsl, r_tsc, n_len,
                                                    8'd0, E_NONE);
                    rec.cnt = rec.cnt + 3'd1;
                    n_mode = M_IDLE;
                end else begin
                    do_flush = 1'b1;
                    do_idle  = 1'b1;
                end
            end
            M_LCOM: begin
                if (b == 8'h0A) n_mode = M_IDLE;
            end
            M_BCOM: begin
                n_len = inc_len(r_len);
                if (b == "*") n_mode = M_BSTAR;
            end
            M_BSTAR: begin
                n_len = inc_len(r_len);
                if (b == "/") n_mode = M_IDLE;
                else if (b != "*") n_mode = M_BCOM;
            end
            M_STR: begin
                n_len = inc_len(r_len);
                if (b == "\"") begin
                    rec.toks[rec.cnt[1:0]] = mk_tok(K_STRING, r_tsl, r_tsc, n_len,
                                                    8'd0, E_NONE);
                    rec.cnt = rec.cnt + 3'd1;
                    n_mode = M_IDLE;
                end
            end
            M_CBODY: begin
                n_len = inc_len(r_len);
                if (b == "\\") begin
                    n_mode = M_CESC;
                end else begin
                    n_esc  = b;
                    n_mode = M_CCLOSE;
                end
            end
            M_CESC: begin
                n_len  = inc_len(r_len);
                n_mode = M_CCLOSE;
                case (b)
                    "0":     n_esc = 8'd0;
                    "a":     n_esc = 8'd7;
                    "b":     n_esc = 8'd8;
                    "f":     n_esc = 8'd12;
                    "n":     n_esc = 8'd10;
                    "r":     n_esc = 8'd13;
                    "t":     n_esc = 8'd9;
                    "\\":    n_esc = 8'd92;
                    "'":     n_esc = 8'd39;
                    "\"":    n_esc = 8'd34;
                    default: begin
                        // unknown escape closes the literal itself
                        n_esc  = 8'd92;
                        n_mode = M_IDLE;
                        rec.toks[rec.cnt[1:0]] = mk_tok(K_CHARACTER, r_tsl, r_tsc, n_len,
                                                        8'd92, E_NONE);
                        rec.cnt = rec.cnt + 3'd1;
                    end
                endcase
            end
            M_CCLOSE: begin
                n_len = inc_len(r_len);
                rec.toks[rec.cnt[1:0]] = mk_tok(K_CHARACTER, r_tsl, r_tsc, n_len,
                                                r_esc, E_NONE);
                rec.cnt = rec.cnt + 3'd1;
                n_mode = M_IDLE;
            end
            M_NUM: begin
                if (is_digit(b)) begin
                    n_len = inc_len(r_len);
                end else begin
                    rec.toks[rec.cnt[1:0]] = mk_tok(K_NUM, r_tsl, r_tsc, r_len,
                                                    8'd0, E_NONE);
                    rec.cnt = rec.cnt + 3'd1;
                    do_idle = 1'b1;
                end
            end
            M_IDENT: begin
                if (is_alpha(b) || is_digit(b)) begin
                    if (r_len < 16'(KEYWORD_MAX_LEN)) begin
                        kw_we  = 1'b1;
                        kw_idx = r_len[IW-1:0];
                        n_kw[r_len[IW-1:0]] = b;
                    end
                    n_len = inc_len(r_len);
                end else begin
                    rec.toks[rec.cnt[1:0]] = mk_tok(classify(wv, r_len), r_tsl, r_tsc, r_len,
                                                    8'd0, E_NONE);
                    rec.cnt = rec.cnt + 3'd1;
                    do_idle = 1'b1;
                end
            end
            default: begin
                do_idle = 1'b1;
            end
        endcase

        if (do_flush) begin
            if (n_len >= 16'd2) begin
                rec.toks[rec.cnt[1:0]] = mk_tok(K_DOT, n_tsl, n_tsc, 16'd1, 8'd0, E_NONE);
                rec.cnt = rec.cnt + 3'd1;
                rec.toks[rec.cnt[1:0]] = mk_tok(K_DOT, n_tsl, inc_col(n_tsc), 16'd1,
                                                8'd0, E_NONE);
                rec.cnt = rec.cnt + 3'd1;
            end else begin
                hk = held_kind(n_pend);
                rec.toks[rec.cnt[1:0]] = mk_tok(hk[8] ? hk[5:0] : K_ERROR, n_tsl, n_tsc,
                                                n_len, 8'd0, hk[8] ? E_NONE : E_UNKNOWN);
                rec.cnt = rec.cnt + 3'd1;
            end
            n_mode = M_IDLE;
        end

        if (do_idle) begin
            hk = held_kind(b);
            pk = imm_kind(b);
            n_mode = M_IDLE;
            if (b == " " || (b >= 8'd9 && b <= 8'd13)) begin
                n_mode = M_IDLE;
            end else if (pk[8]) begin
                rec.toks[rec.cnt[1:0]] = mk_tok(pk[5:0], r_line, col, 16'd1, 8'd0, E_NONE);
                rec.cnt = rec.cnt + 3'd1;
            end else if (hk[8] || b == "\"" || b == "'" || is_digit(b) || is_alpha(b)) begin
                n_tsl = r_line;
                n_tsc = col;
                n_len = 16'd1;
                if (hk[8]) begin
                    n_mode = M_OP;
                    n_pend = b;
                end else if (b == "\"") begin
                    n_mode = M_STR;
                end else if (b == "'") begin
                    n_mode = M_CBODY;
                    n_esc  = 8'd0;
                end else if (is_digit(b)) begin
                    n_mode = M_NUM;
                end else begin
                    n_mode = M_IDENT;
                    kw_we  = 1'b1;
                    kw_idx = '0;
                    n_kw[0] = b;
                end
            end else begin
                rec.toks[rec.cnt[1:0]] = mk_tok(K_ERROR, r_line, col, 16'd1, 8'd0, E_UNKNOWN);
                rec.cnt = rec.cnt + 3'd1;
            end
        end

        if (b == 8'h0A) begin
            n_line = (r_line == LMAX) ? r_line : r_line + LINE_BITS'(1);
            n_col  = '0;
        end else begin
            n_line = r_line;
            n_col  = col;
        end

        if (i_final_byte) begin
            for (int j = 0; j < 8; j++) wv[8*j +: 8] = n_kw[j];
            case (n_mode)
                M_OP: begin
                    if (n_len >= 16'd2) begin
                        rec.toks[rec.cnt[1:0]] = mk_tok(K_DOT, n_tsl, n_tsc, 16'd1,
                                                        8'd0, E_NONE);
                        rec.cnt = rec.cnt + 3'd1;
                        rec.toks[rec.cnt[1:0]] = mk_tok(K_DOT, n_tsl, inc_col(n_tsc), 16'd1,
                                                        8'd0, E_NONE);
                        rec.cnt = rec.cnt + 3'd1;
                    end else begin
                        hk = held_kind(n_pend);
                        rec.toks[rec.cnt[1:0]] = mk_tok(hk[8] ? hk[5:0] : K_ERROR, n_tsl,
                                                        n_tsc, n_len, 8'd0,
                                                        hk[8] ? E_NONE : E_UNKNOWN);
                        rec.cnt = rec.cnt + 3'd1;
                    end
                end
                M_NUM: begin
                    rec.toks[rec.cnt[1:0]] = mk_tok(K_NUM, n_tsl, n_tsc, n_len, 8'd0, E_NONE);
                    rec.cnt = rec.cnt + 3'd1;
                end
                M_IDENT: begin
                    rec.toks[rec.cnt[1:0]] = mk_tok(classify(wv, n_len), n_tsl, n_tsc,
                                                    n_len, 8'd0, E_NONE);
                    rec.cnt = rec.cnt + 3'd1;
                end
                M_BCOM, M_BSTAR: begin
                    rec.toks[rec.cnt[1:0]] = mk_tok(K_ERROR, n_tsl, n_tsc, n_len, 8'd0,
                                                    E_OPEN_COM);
                    rec.cnt = rec.cnt + 3'd1;
                end
                M_STR, M_CBODY, M_CESC, M_CCLOSE: begin
                    rec.toks[rec.cnt[1:0]] = mk_tok(K_ERROR, n_tsl, n_tsc, n_len, 8'd0,
                                                    E_OPEN_LIT);
                    rec.cnt = rec.cnt + 3'd1;
                end
                default: begin
                end
            endcase
            rec.toks[rec.cnt[1:0]] = mk_tok(K_END, n_line, inc_col(n_col), 16'd0,
                                            8'd0, E_NONE);
            rec.cnt = rec.cnt + 3'd1;
            // start a new source
            n_mode = M_IDLE;
            n_pend = 8'd0;
            n_len  = 16'd0;
            n_line = LINE_BITS'(1);
            n_col  = '0;
            n_tsl  = LINE_BITS'(1);
            n_tsc  = '0;
            n_esc  = 8'd0;
        end
    end

    assign accept  = i_valid && !i_full;
    assign o_stall = i_full;
    assign o_push  = accept && (rec.cnt != 3'd0);
    assign o_rec   = rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_pend <= 8'd0;
            r_len  <= 16'd0;
            r_line <= LINE_BITS'(1);
            r_col  <= '0;
            r_tsl  <= LINE_BITS'(1);
            r_tsc  <= '0;
            r_esc  <= 8'd0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_pend <= n_pend;
            r_len  <= n_len;
            r_line <= n_line;
            r_col  <= n_col;
            r_tsl  <= n_tsl;
            r_tsc  <= n_tsc;
            r_esc  <= n_esc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && kw_we) begin
            r_kw[kw_idx] <= n_kw[kw_idx];
        end
    end

endmodule

### hw/rtl/csl_fifo.sv
// Short queue of token records between scanner and token emitter.
module csl_fifo import csl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_rec i_rec,
    input  logic i_pop,
    output t_rec o_head,
    output logic o_empty,
    output logic o_full
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    t_rec          r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_cnt;
    logic          do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (AW+1)'(QUEUE_DEPTH));
    assign o_head  = r_mem[r_rd];
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + AW'(1);
            if (do_pop) r_rd <= r_rd + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_rec;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(QUEUE_DEPTH))
        else $error("queue count out of range");
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pop && !i_push && r_cnt == (AW+1)'(1)) |=> o_empty)
        else $error("queue not empty after last pop");

endmodule

### hw/rtl/csl_back.sv
// Token emitter: unpacks queued records into one output transaction per token.
module csl_back import csl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_rec        i_head,
    input  logic        i_empty,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_token_kind,
    output logic [15:0] o_start_line,
    output logic [11:0] o_start_column,
    output logic [15:0] o_token_length,
    output logic [7:0]  o_literal_value,
    output logic [1:0]  o_error_code,
    output logic        o_run_last
);

    t_rec       r_rec;
    logic [1:0] r_idx;
    logic       r_valid;
    logic       last, load, take;
    t_tok       cur;

    assign cur     = r_rec.toks[r_idx];
    assign last    = ({1'b0, r_idx} + 3'd1) == r_rec.cnt;
    assign take    = r_valid && !i_stall;
    assign load    = !r_valid || (take && last);
    assign o_pop   = load && !i_empty;
    assign o_valid = r_valid;

    assign o_token_kind    = cur.kind;
    assign o_start_line    = cur.line;
    assign o_start_column  = cur.col;
    assign o_token_length  = cur.len;
    assign o_literal_value = cur.lit;
    assign o_error_code    = cur.err;
    assign o_run_last      = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (load) begin
            r_valid <= !i_empty;
            r_idx   <= 2'd0;
        end else if (take) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_rec <= i_head;
    end

    a_idx_in_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ({1'b0, r_idx} < r_rec.cnt))
        else $error("token index beyond record");
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |=> (r_valid && $stable(r_idx)))
        else $error("stalled token moved");

endmodule

### hw/rtl/c_source_lexer.sv
// C source lexer top level: scanner, record queue and token emitter.
// Takes one source byte per cycle while the queue is not full and delivers tokens
// one per cycle while i_stall is low, each with run_last set on the last token that
// a byte caused. The scanner classifies a byte and queues the zero to four tokens it
// completes as one record; a byte that completes k tokens takes k output
// transactions, and the four-record queue lets the input run on while the output
// drains. Bytes that complete nothing (white space, comments, the inside of a token)
// emit no token. The end token follows the final byte; line 1 starts again after it.
module c_source_lexer import csl_pkg::*; #(
    parameter int KEYWORD_MAX_LEN = KEYWORD_MAX_LEN_DEF,
    parameter int LINE_BITS       = LINE_BITS_DEF,
    parameter int COLUMN_BITS     = COLUMN_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_source_byte,
    input  logic        i_final_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_token_kind,
    output logic [15:0] o_start_line,
    output logic [11:0] o_start_column,
    output logic [15:0] o_token_length,
    output logic [7:0]  o_literal_value,
    output logic [1:0]  o_error_code,
    output logic        o_run_last
);

    logic push, pop, empty, full;
    t_rec rec_in, head;

    csl_front #(
        .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN),
        .LINE_BITS       (LINE_BITS),
        .COLUMN_BITS     (COLUMN_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_source_byte (i_source_byte),
        .i_final_byte  (i_final_byte),
        .i_full        (full),
        .o_push        (push),
        .o_rec         (rec_in)
    );

    csl_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (rec_in),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    csl_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .i_empty         (empty),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_token_kind    (o_token_kind),
        .o_start_line    (o_start_line),
        .o_start_column  (o_start_column),
        .o_token_length  (o_token_length),
        .o_literal_value (o_literal_value),
        .o_error_code    (o_error_code),
        .o_run_last      (o_run_last)
    );

endmodule
